@@ design/ima_adpcm_nibble_decoder_u8_defines.svh @@
// Assertion macros for the IMA ADPCM nibble decoder.
`ifndef IMA_ADPCM_NIBBLE_DECODER_U8_DEFINES_SVH
`define IMA_ADPCM_NIBBLE_DECODER_U8_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked assertion with an explicit clock and active-low reset.
`define IMAD_ASSERT_CLK(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion on clk, disabled while arst_n is low.
`define IMAD_ASSERT(label, prop, msg) \
	`IMAD_ASSERT_CLK(label, clk, arst_n, prop, msg)

`else

`define IMAD_ASSERT_CLK(label, clock, rst_n, prop, msg)
`define IMAD_ASSERT(label, prop, msg)

`endif

`endif

@@ design/imad_pkg.sv @@
// Shared types, constants and tables for the IMA ADPCM nibble decoder.
package imad_pkg;

	localparam int StepTableSize = 89;
	localparam int IdxW = 7;
	localparam int PredW = 8;
	localparam int CodeW = 4;
	localparam int StepW = 15;
	localparam int DiffW = 16;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 8;

	localparam logic [IdxW-1:0] MaxIndex = IdxW'(StepTableSize - 1);
	localparam logic [PredW-1:0] PredReset = 8'd127;
	localparam logic [IdxW-1:0] IndexReset = 7'd20;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_START_PREDICTOR = 2'd0,
		CFG_START_INDEX     = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [PredW-1:0] start_predictor;
		logic [IdxW-1:0]  start_index;
	} cfg_t;

	localparam logic [StepW-1:0] StepTable [StepTableSize] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
		15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107,
		15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230,
		15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494,
		15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963, 15'd1060,
		15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066,
		15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026,
		15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845,
		15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289,
		15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
		15'd32767
	};

	function automatic logic [IdxW-1:0] clamp_start(input logic [IdxW-1:0] idx);
		return (idx > MaxIndex) ? MaxIndex : idx;
	endfunction

	function automatic logic [StepW-1:0] step_lookup(input logic [IdxW-1:0] idx);
		return StepTable[clamp_start(idx)];
	endfunction

	// Index move for the three magnitude bits; sign bit does not matter.
	function automatic logic signed [IdxW:0] index_adjust(input logic [2:0] mag);
		logic signed [IdxW:0] adj;
		case (mag)
			3'd4:    adj = 8'sd2;
			3'd5:    adj = 8'sd4;
			3'd6:    adj = 8'sd6;
			3'd7:    adj = 8'sd8;
			default: adj = -8'sd1;
		endcase
		return adj;
	endfunction

endpackage

@@ design/imad_cfg_regs.sv @@
// Start predictor and start index registers behind the write port.
module imad_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [imad_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [imad_pkg::CfgDataW-1:0] cfg_data,
	output imad_pkg::cfg_t                cfg
);

	imad_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_predictor <= imad_pkg::PredReset;
			cfg_q.start_index     <= imad_pkg::IndexReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				imad_pkg::CFG_START_PREDICTOR: cfg_q.start_predictor <= cfg_data;
				imad_pkg::CFG_START_INDEX:
					cfg_q.start_index <= cfg_data[imad_pkg::IdxW-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/imad_core.sv @@
// Decoder state and the single-pass predictor and step index update.
`include "ima_adpcm_nibble_decoder_u8_defines.svh"

module imad_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [imad_pkg::CodeW-1:0]   code,
	input  logic                         restart,
	input  imad_pkg::cfg_t               cfg,
	output logic [imad_pkg::PredW-1:0]   sample_next
);

	logic [imad_pkg::PredW-1:0]   pred_q;
	logic [imad_pkg::IdxW-1:0]    idx_q;
	logic [imad_pkg::PredW-1:0]   pred_base;
	logic [imad_pkg::IdxW-1:0]    idx_base;
	logic [imad_pkg::IdxW-1:0]    idx_next;
	logic signed [imad_pkg::IdxW:0] idx_sum;
	logic [imad_pkg::StepW-1:0]   step;
	logic [imad_pkg::DiffW-1:0]   diff;
	logic signed [imad_pkg::DiffW+1:0] pred_sum;
	logic [2:0]                   mag;

	assign mag = code[2:0];

	always_comb begin
		pred_base = restart ? cfg.start_predictor : pred_q;
		idx_base  = restart ? imad_pkg::clamp_start(cfg.start_index) : idx_q;
		step      = imad_pkg::step_lookup(idx_base);

		idx_sum = $signed({1'b0, idx_base}) + imad_pkg::index_adjust(mag);
		if (idx_sum < 0)
			idx_next = '0;
		else if (idx_sum > $signed({1'b0, imad_pkg::MaxIndex}))
			idx_next = imad_pkg::MaxIndex;
		else
			idx_next = idx_sum[imad_pkg::IdxW-1:0];

		// Shift-add multiply of step by (mag + 0.5) / 4.
		diff = imad_pkg::DiffW'(step >> 3);
		if (mag[2])
			diff = diff + imad_pkg::DiffW'(step);
		if (mag[1])
			diff = diff + imad_pkg::DiffW'(step >> 1);
		if (mag[0])
			diff = diff + imad_pkg::DiffW'(step >> 2);

		if (code[3])
			pred_sum = $signed({10'd0, pred_base}) - $signed({2'd0, diff});
		else
			pred_sum = $signed({10'd0, pred_base}) + $signed({2'd0, diff});

		// Saturate to the unsigned sample range.
		if (pred_sum < 0)
			sample_next = '0;
		else if (pred_sum > 18'sd255)
			sample_next = '1;
		else
			sample_next = pred_sum[imad_pkg::PredW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= imad_pkg::PredReset;
			idx_q  <= imad_pkg::IndexReset;
		end else if (advance) begin
			pred_q <= sample_next;
			idx_q  <= idx_next;
		end
	end

	`IMAD_ASSERT(a_idx_range, idx_q <= imad_pkg::MaxIndex, "step index left table range")
	`IMAD_ASSERT(a_hold_state, !advance |=> $stable(pred_q) && $stable(idx_q), "state moved without a beat")
	`IMAD_ASSERT(a_pred_load, advance |=> pred_q == $past(sample_next), "predictor not loaded from result")
	`IMAD_ASSERT(a_pos_step, advance && !restart && !code[3] |=> pred_q >= $past(pred_q), "positive code lowered predictor")
	`IMAD_ASSERT(a_neg_step, advance && !restart && code[3] |=> pred_q <= $past(pred_q), "negative code raised predictor")

endmodule

@@ design/ima_adpcm_nibble_decoder_u8.sv @@
// An accepted beat passes the input register and then the output register to out_valid.
// Throughput: one nibble per cycle unless out_stall holds the output; the input register
// and the output register each hold one beat, so one more beat is taken while a finished sample waits.
// Reset: start_predictor and predictor go to 127, start_index and step index to 20,
// both pipeline stages empty.
module ima_adpcm_nibble_decoder_u8 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [imad_pkg::CodeW-1:0]    code_nibble,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [imad_pkg::PredW-1:0]    sample,
	input  logic                          cfg_wr_en,
	input  logic [imad_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [imad_pkg::CfgDataW-1:0] cfg_data
);

	imad_pkg::cfg_t              cfg;
	logic                        valid_s1;
	logic [imad_pkg::CodeW-1:0]  code_s1;
	logic                        restart_s1;
	logic                        out_valid_q;
	logic [imad_pkg::PredW-1:0]  sample_q;
	logic [imad_pkg::PredW-1:0]  sample_next;
	logic                        out_blocked;
	logic                        advance;
	logic                        in_take;

	imad_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	imad_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.code        (code_s1),
		.restart     (restart_s1),
		.cfg         (cfg),
		.sample_next (sample_next)
	);

	assign out_blocked = out_valid_q & out_stall;
	assign advance     = valid_s1 & ~out_blocked;
	assign in_stall    = valid_s1 & out_blocked;
	assign in_take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			code_s1    <= code_nibble;
			restart_s1 <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the sample while the downstream side stalls.
	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q <= sample_next;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the IMA ADPCM nibble decoder with unsigned 8-bit samples.
module tb;
	import imad_pkg::*;

	localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
	localparam int LastIndex = 88;
	localparam int CycleLimit = 400000;
	localparam int PhaseItems = 345;

	localparam int unsigned StepSizes [89] = '{
		7, 8, 9, 10, 11, 12, 13, 14, 16, 17,
		19, 21, 23, 25, 28, 31, 34, 37, 41, 45,
		50, 55, 60, 66, 73, 80, 88, 97, 107, 118,
		130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
		337, 371, 408, 449, 494, 544, 598, 658, 724, 796,
		876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
		2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358,
		5894, 6484, 7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899,
		15289, 16818, 18500, 20350, 22385, 24623, 27086, 29794, 32767
	};

	// Tracks decoder state and the samples still owed by the block.
	class decoded_sample_board;
		logic [PredW-1:0] start_pred;
		logic [IdxW-1:0]  start_idx;
		logic [PredW-1:0] pred;
		logic [IdxW-1:0]  idx;
		logic [PredW-1:0] samples_due [$];
		int errors;

		function new();
			start_pred = 8'd127;
			start_idx = 7'd20;
			pred = 8'd127;
			idx = 7'd20;
			errors = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] reg_idx, logic [CfgDataW-1:0] data);
			case (reg_idx)
				CFG_START_PREDICTOR: start_pred = data;
				CFG_START_INDEX: start_idx = data[IdxW-1:0];
				default: ;
			endcase
		endfunction

		function void take_nibble(logic [CodeW-1:0] code, logic reload);
			int stp;
			int diff;
			int p;
			int next_idx;
			if (reload) begin
				pred = start_pred;
				idx = (start_idx > LastIndex) ? IdxW'(LastIndex) : start_idx;
			end
			stp = StepSizes[idx];
			// small magnitudes back off by one, large ones jump by 2, 4, 6 or 8
			if (code[2])
				next_idx = int'(idx) + 2 * (int'(code[1:0]) + 1);
			else
				next_idx = int'(idx) - 1;
			if (next_idx < 0)
				next_idx = 0;
			else if (next_idx > LastIndex)
				next_idx = LastIndex;
			idx = IdxW'(next_idx);
			diff = stp >> 3;
			if (code[2])
				diff += stp;
			if (code[1])
				diff += stp >> 1;
			if (code[0])
				diff += stp >> 2;
			p = code[3] ? int'(pred) - diff : int'(pred) + diff;
			if (p > 255)
				p = 255;
			else if (p < 0)
				p = 0;
			pred = PredW'(p);
			samples_due.push_back(pred);
		endfunction

		function void check_sample(logic [PredW-1:0] got);
			logic [PredW-1:0] want;
			if (samples_due.size() == 0) begin
				errors++;
				$error("sample: expected none, got %0d", got);
			end else begin
				want = samples_due.pop_front();
				if (got !== want) begin
					errors++;
					$error("sample: expected %0d, got %0d", want, got);
				end
			end
		endfunction

		function int pending();
			return samples_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CodeW-1:0] code_nibble = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PredW-1:0] sample;
	logic cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	decoded_sample_board board;

	ima_adpcm_nibble_decoder_u8 u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_nibble(code_nibble),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Note accepted nibbles before checking samples so a combinational path would still line up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.take_nibble(code_nibble, restart);
			if (out_valid && !out_stall)
				board.check_sample(sample);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_nibble(input logic [CodeW-1:0] code, input logic reload);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		code_nibble <= code;
		restart <= reload;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop in_valid and wait on the clock before polling, so the beat accepted at the last edge is already counted.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] reg_idx, input logic [CfgDataW-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_reg(reg_idx, data);
		cfg_wr_en <= 1'b0;
	endtask

	// Mix stretches of plain random codes with runs that push the step index up or down.
	task automatic run_phase(input int idle, input int stall);
		int sent;
		int run_len;
		int flavor;
		logic [CodeW-1:0] code;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < PhaseItems) begin
			flavor = $urandom_range(2);
			run_len = $urandom_range(60, 10);
			for (int k = 0; k < run_len && sent < PhaseItems; k++) begin
				code = CodeW'($urandom_range(15));
				if (flavor == 1)
					code[2] = 1'b1;
				else if (flavor == 2)
					code[2] = 1'b0;
				send_nibble(code, $urandom_range(31) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every code from the reset state, one reload on the way
		for (int c = 0; c < 16; c++)
			send_nibble(CodeW'(c), c == 12);

		// top of the table and top of the range: saturate high, then crash to zero
		drain();
		cfg_write(CFG_START_PREDICTOR, 8'd255);
		cfg_write(CFG_START_INDEX, 8'd88);
		send_nibble(4'd7, 1'b1);
		send_nibble(4'd7, 1'b0);
		send_nibble(4'd15, 1'b1);

		// unused register ignored; oversized start index clamps to the top entry
		drain();
		cfg_write(CfgIdxUnused, 8'h55);
		cfg_write(CFG_START_PREDICTOR, 8'd0);
		cfg_write(CFG_START_INDEX, 8'hFF);
		send_nibble(4'd8, 1'b1);
		send_nibble(4'd0, 1'b0);

		// bit 7 of the index data is dropped, leaving index zero
		drain();
		cfg_write(CFG_START_INDEX, 8'h80);
		cfg_write(CFG_START_PREDICTOR, 8'h80);
		send_nibble(4'd0, 1'b1);
		send_nibble(4'd11, 1'b0);

		drain();
		cfg_write(CFG_START_PREDICTOR, 8'd0);
		cfg_write(CFG_START_INDEX, 8'd0);
		run_phase(0, 0);

		drain();
		cfg_write(CFG_START_PREDICTOR, 8'd255);
		cfg_write(CFG_START_INDEX, 8'd88);
		run_phase(60, 0);

		drain();
		cfg_write(CFG_START_PREDICTOR, CfgDataW'($urandom_range(255)));
		cfg_write(CFG_START_INDEX, CfgDataW'($urandom_range(255)));
		run_phase(0, 60);

		drain();
		cfg_write(CFG_START_PREDICTOR, CfgDataW'($urandom_range(255)));
		cfg_write(CFG_START_INDEX, CfgDataW'($urandom_range(88)));
		run_phase(23, 23);

		drain();
		repeat (4) @(posedge clk);
		if (board.pending() != 0) begin
			board.errors++;
			$error("sample: %0d expected beats never arrived", board.pending());
		end
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
